[design/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants of the page frame allocator
// Field widths, mode codes and the command/status structs that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    localparam int unsigned FRAME_W        = 12;
    localparam int unsigned COUNT_W        = 13;
    localparam int unsigned TABLE_DEPTH    = 4096;
    localparam int unsigned NUM_FRAMES_DEF = 4096;

    // item mode codes
    localparam logic MODE_FREE  = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic do_push;    // write link, head <= frame, count + 1
        logic do_pop;     // read link of head, count - 1
        logic load_head;  // head <= link read data
        logic emit;       // register a result this cycle
        logic ok;         // success flag of that result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_status;

endpackage

`default_nettype wire

[design/pfa_ctrl.sv]
// ----------------------------------------------------------------------------
// pfa_ctrl: allocator controller
// Accepts items and sequences the pop: link read, then head load.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire logic                i_mode,
    input  pfa_pkg::t_dp_status      i_status,
    output logic                     busy,
    output pfa_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.emit = 1'b1;
                    if (i_mode == pfa_pkg::MODE_ALLOC) begin
                        if (!i_status.empty) begin
                            o_cmd.do_pop = 1'b1;
                            o_cmd.ok     = 1'b1;
                            n_state      = S_POP;
                        end
                    end else begin
                        if (!i_status.full) begin
                            o_cmd.do_push = 1'b1;
                            o_cmd.ok      = 1'b1;
                        end
                    end
                end
            end
            S_POP: begin
                // link data is back: it becomes the new head
                o_cmd.load_head = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state == S_POP);

endmodule

`default_nettype wire

[design/pfa_datapath.sv]
// ----------------------------------------------------------------------------
// pfa_datapath: allocator datapath
// Head register, free count, link memory and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_datapath #(
    parameter int unsigned NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  pfa_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [pfa_pkg::FRAME_W-1:0]   i_frame_number,
    output pfa_pkg::t_dp_status                o_status,
    output logic                               o_done,
    output logic [pfa_pkg::FRAME_W-1:0]        o_frame_out,
    output logic                               o_ok,
    output logic [pfa_pkg::COUNT_W-1:0]        o_free_count
);

    // capacity saturates at the table depth
    localparam int unsigned CountCap =
        (NUM_FRAMES < pfa_pkg::TABLE_DEPTH) ? NUM_FRAMES : pfa_pkg::TABLE_DEPTH;

    logic [pfa_pkg::FRAME_W-1:0] r_link_mem [pfa_pkg::TABLE_DEPTH];
    logic [pfa_pkg::FRAME_W-1:0] r_rd_data;
    logic [pfa_pkg::FRAME_W-1:0] r_head;
    logic [pfa_pkg::FRAME_W-1:0] n_head;
    logic [pfa_pkg::COUNT_W-1:0] r_count;
    logic [pfa_pkg::COUNT_W-1:0] n_count;
    logic                        r_done;
    logic [pfa_pkg::FRAME_W-1:0] r_frame_out;
    logic                        r_ok;
    logic [pfa_pkg::COUNT_W-1:0] r_free_count;

    // link memory: one write port (push), one registered read port (pop)
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_push) begin
            r_link_mem[i_frame_number] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_pop) begin
            r_rd_data <= r_link_mem[r_head];
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.do_push) begin
            n_head  = i_frame_number;
            n_count = r_count + pfa_pkg::COUNT_W'(1);
        end else if (i_cmd.do_pop) begin
            n_count = r_count - pfa_pkg::COUNT_W'(1);
        end
        if (i_cmd.load_head) begin
            n_head = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= i_cmd.emit;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_frame_out  <= i_cmd.do_pop ? r_head : '0;
            r_ok         <= i_cmd.ok;
            r_free_count <= n_count;
        end
    end

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count >= pfa_pkg::COUNT_W'(CountCap));
    assign o_done         = r_done;
    assign o_frame_out    = r_frame_out;
    assign o_ok           = r_ok;
    assign o_free_count   = r_free_count;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pfa_pkg::COUNT_W'(CountCap))
        else $error("free count above capacity");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_pop |=> (r_count == $past(r_count) - pfa_pkg::COUNT_W'(1)))
        else $error("pop did not decrement free count");

    a_load_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_pop |=> i_cmd.load_head)
        else $error("head load missing after link read");

endmodule

`default_nettype wire

[design/page_frame_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator: linked LIFO free list of page frames
// Free pushes a frame (its link takes the old head), allocate pops the
// head; every item returns one result with the running free count.
// ----------------------------------------------------------------------------
// Every result appears on o_done in the cycle after its item is taken.
// A free, or an allocate on an empty list, leaves busy low, so the next item
//   can be taken at once; a successful allocate holds busy while the popped
//   frame's link comes back from the synchronous link memory to the head.
// Reset (i_rst_n, synchronous): head and free count cleared, list empty;
//   link memory is not cleared. Results cannot be stalled by the receiver.
`default_nettype none

module page_frame_free_list_allocator #(
    parameter int unsigned NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_mode,
    input  wire logic [pfa_pkg::FRAME_W-1:0]   i_frame_number,
    output logic                               o_done,
    output logic [pfa_pkg::FRAME_W-1:0]        o_frame_out,
    output logic                               o_ok,
    output logic [pfa_pkg::COUNT_W-1:0]        o_free_count
);

    localparam int unsigned CountCap =
        (NUM_FRAMES < pfa_pkg::TABLE_DEPTH) ? NUM_FRAMES : pfa_pkg::TABLE_DEPTH;

    pfa_pkg::t_dp_cmd    cmd;
    pfa_pkg::t_dp_status status;
    logic                accept;

    // start is only acted on while not busy
    assign accept = start && !busy;

    pfa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (accept),
        .i_mode   (i_mode),
        .i_status (status),
        .busy     (busy),
        .o_cmd    (cmd)
    );

    pfa_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_frame_number (i_frame_number),
        .o_status       (status),
        .o_done         (o_done),
        .o_frame_out    (o_frame_out),
        .o_ok           (o_ok),
        .o_free_count   (o_free_count)
    );

    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("item without result");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_frame_out == '0))
        else $error("failed item returned a frame");

    a_out_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_free_count <= pfa_pkg::COUNT_W'(CountCap)))
        else $error("reported free count above capacity");

endmodule

`default_nettype wire

[tb/tb_page_frame_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// tb_page_frame_free_list_allocator: self-checking bench for the frame free list
// Drives free and allocate items through the start/busy handshake, keeps a
// shadow LIFO of frames (links, head, free count) and checks every o_done
// result field by field. Covers the empty list, a deep fill and drain, double
// frees and the extreme frame numbers, then random bursts under several
// sender idle rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_page_frame_free_list_allocator;

    localparam int unsigned NUM_FRAMES = pfa_pkg::NUM_FRAMES_DEF;
    localparam int unsigned CAPACITY   = (NUM_FRAMES < 4096) ? NUM_FRAMES : 4096;
    localparam int          FILL_DEPTH = 64;    // depth of the fill and drain phase
    localparam int          STALL_MAX  = 2000;  // cycles with no item taken and no result
    localparam int          MAX_SHOWN  = 10;

    typedef struct {
        logic                        mode;
        logic [pfa_pkg::FRAME_W-1:0] frame;
    } t_frame_req;

    typedef struct {
        logic [pfa_pkg::FRAME_W-1:0] frame;
        logic                        ok;
        logic [pfa_pkg::COUNT_W-1:0] count;
    } t_frame_grant;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        start          = 1'b0;
    logic                        i_mode         = pfa_pkg::MODE_FREE;
    logic [pfa_pkg::FRAME_W-1:0] i_frame_number = '0;
    logic                        busy;
    logic                        o_done;
    logic [pfa_pkg::FRAME_W-1:0] o_frame_out;
    logic                        o_ok;
    logic [pfa_pkg::COUNT_W-1:0] o_free_count;

    page_frame_free_list_allocator #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_frame_number (i_frame_number),
        .o_done         (o_done),
        .o_frame_out    (o_frame_out),
        .o_ok           (o_ok),
        .o_free_count   (o_free_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // items waiting for the driver, grants waiting for o_done
    t_frame_req   req_queue[$];
    t_frame_grant grants_due[$];

    // shadow of the free list
    logic [pfa_pkg::FRAME_W-1:0] shadow_links [pfa_pkg::TABLE_DEPTH];
    logic [pfa_pkg::FRAME_W-1:0] shadow_head  = '0;
    logic [pfa_pkg::COUNT_W-1:0] shadow_free  = '0;

    int   idle_pct      = 0;
    int   mismatches    = 0;
    int   stall_cycles  = 0;
    int   gen_level     = 0;   // generator's own idea of the list depth
    logic taken         = 1'b0;

    // One item through the shadow list: same rules as the block, one grant out.
    task automatic free_list_step(input logic mode,
                                  input logic [pfa_pkg::FRAME_W-1:0] frame,
                                  output t_frame_grant grant);
        grant.frame = '0;
        grant.ok    = 1'b0;
        if (mode == pfa_pkg::MODE_ALLOC) begin
            if (shadow_free != 0) begin
                grant.frame = shadow_head;
                shadow_head = shadow_links[shadow_head];
                shadow_free = shadow_free - 1'b1;
                grant.ok    = 1'b1;
            end
        end else if (shadow_free < CAPACITY) begin
            shadow_links[frame] = shadow_head;
            shadow_head         = frame;
            shadow_free         = shadow_free + 1'b1;
            grant.ok            = 1'b1;
        end
        grant.count = shadow_free;
    endtask

    // Queue one item; the generator tracks depth so bursts on an empty list lean to frees.
    task automatic queue_item(input logic mode, input logic [pfa_pkg::FRAME_W-1:0] frame);
        t_frame_req req;
        req.mode  = mode;
        req.frame = frame;
        req_queue.push_back(req);
        if (mode == pfa_pkg::MODE_ALLOC) begin
            if (gen_level > 0) gen_level--;
        end else if (gen_level < CAPACITY) begin
            gen_level++;
        end
    endtask

    // Random frame: mostly full range, sometimes a tiny pool so frames repeat
    // (double frees) and the extreme values turn up.
    function automatic logic [pfa_pkg::FRAME_W-1:0] pick_frame();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return pfa_pkg::FRAME_W'($urandom_range(7));
        if (r < 25)
            return {pfa_pkg::FRAME_W{1'b1}} - pfa_pkg::FRAME_W'($urandom_range(3));
        return pfa_pkg::FRAME_W'($urandom);
    endfunction

    // Bursts of frees and allocates with random content, plus odd single items.
    task automatic queue_random(input int n_items);
        int   issued;
        int   burst;
        logic dir;
        issued = 0;
        while (issued < n_items) begin
            if ($urandom_range(99) < 15) begin
                queue_item(logic'($urandom_range(1)), pick_frame());
                issued++;
            end else begin
                burst = $urandom_range(1, 10);
                if (gen_level == 0)
                    dir = ($urandom_range(99) < 80) ? pfa_pkg::MODE_FREE : pfa_pkg::MODE_ALLOC;
                else
                    dir = logic'($urandom_range(1));
                for (int k = 0; k < burst && issued < n_items; k++) begin
                    queue_item(dir, pick_frame());
                    issued++;
                end
            end
        end
    endtask

    // Hold off until the driver is empty and every grant has come back.
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (req_queue.size() != 0 || start || grants_due.size() != 0);
    endtask

    // Driver: new item at the falling edge once the previous one was taken.
    always @(negedge i_clk) begin
        t_frame_req req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            // still waiting for the block to take it
        end else if (req_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req             = req_queue.pop_front();
            start          <= 1'b1;
            i_mode         <= req.mode;
            i_frame_number <= req.frame;
        end else begin
            start          <= 1'b0;
            i_mode         <= logic'($urandom_range(1));
            i_frame_number <= pfa_pkg::FRAME_W'($urandom);
        end
    end

    // Monitor: predict on acceptance, check each strobed result against the oldest.
    always @(posedge i_clk) begin
        t_frame_grant want;
        t_frame_grant fresh;
        if (!i_rst_n) begin
            taken <= 1'b0;
        end else begin
            taken <= start && !busy;
            if (o_done) begin
                if (grants_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: frame %0d ok %0b count %0d",
                                 o_frame_out, o_ok, o_free_count);
                end else begin
                    want = grants_due.pop_front();
                    if (o_frame_out !== want.frame || o_ok !== want.ok
                            || o_free_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch frame/ok/count: want %0d/%0b/%0d got %0d/%0b/%0d",
                                     want.frame, want.ok, want.count,
                                     o_frame_out, o_ok, o_free_count);
                    end
                end
            end
            if (start && !busy) begin
                free_list_step(i_mode, i_frame_number, fresh);
                grants_due.push_back(fresh);
            end
        end
    end

    // Watchdog: too long with neither an item taken nor a result seen.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty list, extreme frames, LIFO order, double free
        idle_pct = 0;
        queue_item(pfa_pkg::MODE_ALLOC, {pfa_pkg::FRAME_W{1'b1}});   // allocate on empty list
        queue_item(pfa_pkg::MODE_FREE,  '0);
        queue_item(pfa_pkg::MODE_FREE,  {pfa_pkg::FRAME_W{1'b1}});
        queue_item(pfa_pkg::MODE_FREE,  12'hAAA);
        queue_item(pfa_pkg::MODE_FREE,  12'h555);
        queue_item(pfa_pkg::MODE_ALLOC, 12'h123);
        queue_item(pfa_pkg::MODE_ALLOC, '0);
        queue_item(pfa_pkg::MODE_ALLOC, 12'hFFF);
        queue_item(pfa_pkg::MODE_ALLOC, 12'h800);
        queue_item(pfa_pkg::MODE_ALLOC, 12'h001);           // empty again
        queue_item(pfa_pkg::MODE_FREE,  12'h7FF);
        queue_item(pfa_pkg::MODE_FREE,  12'h7FF);           // double free, counted twice
        queue_item(pfa_pkg::MODE_FREE,  12'h800);
        queue_item(pfa_pkg::MODE_ALLOC, '0);
        queue_item(pfa_pkg::MODE_ALLOC, '0);
        queue_item(pfa_pkg::MODE_ALLOC, '0);
        queue_item(pfa_pkg::MODE_ALLOC, '0);
        wait_quiet();

        // deep fill with a few extra pushes, then drain past empty
        for (int k = 0; k < FILL_DEPTH; k++)
            queue_item(pfa_pkg::MODE_FREE, pfa_pkg::FRAME_W'(k ^ $urandom_range(1)));
        queue_item(pfa_pkg::MODE_FREE,  12'h3C3);
        queue_item(pfa_pkg::MODE_FREE,  {pfa_pkg::FRAME_W{1'b1}});
        queue_item(pfa_pkg::MODE_ALLOC, '0);
        queue_item(pfa_pkg::MODE_FREE,  12'hC3C);
        queue_item(pfa_pkg::MODE_FREE,  '0);
        for (int k = 0; k < FILL_DEPTH + 5; k++)
            queue_item(pfa_pkg::MODE_ALLOC, pick_frame());
        wait_quiet();

        // random bursts, back to back
        queue_random(100);
        wait_quiet();

        // sender mostly idle
        idle_pct = 59;
        queue_random(100);
        wait_quiet();

        // light idling
        idle_pct = 7;
        queue_random(100);
        wait_quiet();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && grants_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
